// ===== hdl/pirl_pkg.sv =====
`timescale 1ns / 1ps
// pirl_pkg: shared types and constants for the positional insert/remove list
// holds op and status codes, widths and the control bundle sent to each cell
// no dependencies
package pirl_pkg;

   // default store size and read-gather grouping
   localparam int DEFAULT_CAPACITY = 128;
   localparam int GATHER_GROUP     = 8;

   // field widths
   localparam int DATA_W  = 32;
   localparam int POS_W   = 8;
   localparam int COUNT_W = 8;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_POS   = 2'd3
   } status_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic                     ins;
      logic                     rem;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ===== hdl/pirl_cell.sv =====
`timescale 1ns / 1ps
// pirl_cell: one list entry of the shift chain
// takes its left or right neighbor on insert/remove and offers its word on a hit
// depends on pirl_pkg
module pirl_cell #(
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  pirl_pkg::cell_ctrl_type           ctrl,
   input  logic signed [pirl_pkg::DATA_W-1:0] left_entry,
   input  logic signed [pirl_pkg::DATA_W-1:0] right_entry,
   output logic signed [pirl_pkg::DATA_W-1:0] entry,
   output logic signed [pirl_pkg::DATA_W-1:0] hit_data
);

   logic signed [pirl_pkg::DATA_W-1:0] entry_ff;
   logic signed [pirl_pkg::DATA_W-1:0] entry_in;
   logic                               at_pos;
   logic                               above_pos;

   // position compare against this cell's fixed place
   assign at_pos    = (int'(ctrl.pos) == INDEX);
   assign above_pos = (int'(ctrl.pos) < INDEX);

   // next entry: shift up, load value, shift down or hold
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (above_pos) begin
            entry_in = left_entry;
         end else if (at_pos) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.rem) begin
         if (above_pos || at_pos) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry    = entry_ff;
   // word offered to the read gather, zero unless this cell is addressed
   assign hit_data = at_pos ? entry_ff : '0;

endmodule

// ===== hdl/pirl_gather.sv =====
`timescale 1ns / 1ps
// pirl_gather: registered or-tree that collects the addressed cell's word
// first level ors groups of cells into registers, second level ors the groups
// depends on pirl_pkg
module pirl_gather #(
   parameter int CAPACITY = pirl_pkg::DEFAULT_CAPACITY
) (
   input  logic                               clock,
   input  logic signed [pirl_pkg::DATA_W-1:0] hit_data [CAPACITY],
   output logic signed [pirl_pkg::DATA_W-1:0] word_out
);

   localparam int GRP  = pirl_pkg::GATHER_GROUP;
   localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

   logic signed [pirl_pkg::DATA_W-1:0] grp_in [NGRP];
   logic signed [pirl_pkg::DATA_W-1:0] grp_ff [NGRP];

   // first level: or within each group of cells
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GRP; k++) begin
            if (g * GRP + k < CAPACITY) begin
               grp_in[g] = grp_in[g] | hit_data[g * GRP + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   // second level: or across the group registers
   always_comb begin
      word_out = '0;
      for (int g = 0; g < NGRP; g++) begin
         word_out = word_out | grp_ff[g];
      end
   end

endmodule

// ===== hdl/positional_insert_remove_list.sv =====
`timescale 1ns / 1ps
// positional_insert_remove_list: ordered list of signed 32-bit values
// top level with count control, the cell chain and the read gather
// depends on pirl_pkg, pirl_cell, pirl_gather
//
// Usage:
//   A request (req_op, req_value, req_position) is taken at a rising edge
//   with start high and busy low. busy stays low: a new request may be
//   issued every cycle.
//   Ops: insert at position, remove at position, read at position. Each
//   request gives exactly one response on rsp_status, rsp_data_out and
//   rsp_entry_count, marked by rsp_valid for one cycle.
//   Each response is registered in the s1 stage and then in the rsp stage
//   before rsp_valid rises. Throughput is one request per cycle.
//   Every entry is a cell of a shift chain; on an insert or remove all cells
//   move at once in the accept cycle, so the next request sees the new list.
//   The read word passes a two-level or-tree; its first level is registered
//   and its second level feeds the rsp register.
//   Reset clears the entry count and the response pipeline; cell contents
//   are left as they are and are never read before being written.
//   The receiver cannot stall: each response is taken in its strobe cycle.
module positional_insert_remove_list #(
   parameter int CAPACITY = pirl_pkg::DEFAULT_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_op,
   input  logic signed [pirl_pkg::DATA_W-1:0] req_value,
   input  logic [pirl_pkg::POS_W-1:0]         req_position,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic signed [pirl_pkg::DATA_W-1:0] rsp_data_out,
   output logic [pirl_pkg::COUNT_W-1:0]       rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > pirl_pkg::POS_W) ?
                          ((CNT_W > pirl_pkg::COUNT_W) ? CNT_W : pirl_pkg::COUNT_W) :
                          ((pirl_pkg::POS_W > pirl_pkg::COUNT_W) ?
                           pirl_pkg::POS_W : pirl_pkg::COUNT_W);

   logic                          accept;
   logic [CNT_W-1:0]              cnt_ff;
   logic [CNT_W-1:0]              cnt_in;
   logic [CMP_W-1:0]              cnt_ext;
   logic [CMP_W-1:0]              cnt_next_ext;
   logic [CMP_W-1:0]              pos_ext;
   logic                          full;
   logic                          empty;
   pirl_pkg::status_type          status;
   logic                          do_ins;
   logic                          do_rem;
   logic                          want_data;
   pirl_pkg::cell_ctrl_type       ctrl;

   logic                          s1_valid_ff;
   pirl_pkg::status_type          s1_status_ff;
   logic                          s1_data_en_ff;
   logic [pirl_pkg::COUNT_W-1:0]  s1_count_ff;

   logic                               rsp_valid_ff;
   logic [1:0]                         rsp_status_ff;
   logic signed [pirl_pkg::DATA_W-1:0] rsp_data_ff;
   logic [pirl_pkg::COUNT_W-1:0]       rsp_count_ff;

   logic signed [pirl_pkg::DATA_W-1:0] entry_w [CAPACITY];
   logic signed [pirl_pkg::DATA_W-1:0] hit_w   [CAPACITY];
   logic signed [pirl_pkg::DATA_W-1:0] gather_word;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // widen count and position to a common compare width
   assign cnt_ext = CMP_W'(cnt_ff);
   assign pos_ext = CMP_W'(req_position);
   assign full    = (cnt_ff == CNT_W'(CAPACITY));
   assign empty   = (cnt_ff == '0);

   // request decode and status
   always_comb begin
      status    = pirl_pkg::ST_OK;
      do_ins    = 1'b0;
      do_rem    = 1'b0;
      want_data = 1'b0;
      case (req_op)
         pirl_pkg::OP_INSERT: begin
            if (full) begin
               status = pirl_pkg::ST_FULL;
            end else if (pos_ext > cnt_ext) begin
               status = pirl_pkg::ST_POS;
            end else begin
               do_ins = accept;
            end
         end
         pirl_pkg::OP_REMOVE, pirl_pkg::OP_READ: begin
            if (empty) begin
               status = pirl_pkg::ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               status = pirl_pkg::ST_POS;
            end else begin
               want_data = 1'b1;
               do_rem    = accept && (req_op == pirl_pkg::OP_REMOVE);
            end
         end
         default: begin
            status = pirl_pkg::ST_OK;
         end
      endcase
   end

   // entry count update
   always_comb begin
      cnt_in = cnt_ff;
      if (do_ins) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_rem) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end
   assign cnt_next_ext = CMP_W'(cnt_in);

   // control broadcast to the cells
   assign ctrl.ins   = do_ins;
   assign ctrl.rem   = do_rem;
   assign ctrl.pos   = req_position;
   assign ctrl.value = req_value;

   // chain of entry cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [pirl_pkg::DATA_W-1:0] left_w;
      logic signed [pirl_pkg::DATA_W-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_left
         assign left_w = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_right
         assign right_w = entry_w[i+1];
      end
      pirl_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_entry (left_w),
         .right_entry(right_w),
         .entry      (entry_w[i]),
         .hit_data   (hit_w[i])
      );
   end

   // read gather of the addressed entry, taken before the shift
   pirl_gather #(
      .CAPACITY(CAPACITY)
   ) u_gather (
      .clock   (clock),
      .hit_data(hit_w),
      .word_out(gather_word)
   );

   // count register and response pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s1_status_ff  <= pirl_pkg::ST_OK;
         s1_data_en_ff <= 1'b0;
         s1_count_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= '0;
         rsp_data_ff   <= '0;
         rsp_count_ff  <= '0;
      end else begin
         cnt_ff        <= cnt_in;
         s1_valid_ff   <= accept;
         s1_status_ff  <= status;
         s1_data_en_ff <= want_data;
         s1_count_ff   <= cnt_next_ext[pirl_pkg::COUNT_W-1:0];
         rsp_valid_ff  <= s1_valid_ff;
         rsp_status_ff <= s1_status_ff;
         rsp_data_ff   <= s1_data_en_ff ? gather_word : '0;
         rsp_count_ff  <= s1_count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== hdl/pirl_chk.sv =====
`timescale 1ns / 1ps
// pirl_chk: port-level checks for positional_insert_remove_list
// watches the request and response ports; bound to the top level below
// depends on pirl_pkg and positional_insert_remove_list
module pirl_chk #(
   parameter int CAPACITY = pirl_pkg::DEFAULT_CAPACITY
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [1:0]                         rsp_status,
   input logic signed [pirl_pkg::DATA_W-1:0] rsp_data_out,
   input logic [pirl_pkg::COUNT_W-1:0]       rsp_entry_count
);

   // every accepted request is answered by rsp_valid
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_valid)
      else $error("response missing two cycles after request");

   // no response without an earlier request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> ##1 !rsp_valid)
      else $error("response without request");

   // rejected requests return zero data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != pirl_pkg::ST_OK) |-> (rsp_data_out == '0))
      else $error("nonzero data on rejected request");

   // full and empty statuses agree with the reported count
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pirl_pkg::ST_FULL) |->
         (rsp_entry_count == pirl_pkg::COUNT_W'(CAPACITY)))
      else $error("full status with wrong count");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pirl_pkg::ST_EMPTY) |-> (rsp_entry_count == '0))
      else $error("empty status with nonzero count");

endmodule

bind positional_insert_remove_list pirl_chk #(
   .CAPACITY(CAPACITY)
) u_pirl_chk (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_data_out   (rsp_data_out),
   .rsp_entry_count(rsp_entry_count)
);

// ===== tb/sv/tb_positional_insert_remove_list.sv =====
`timescale 1ns / 1ps
// tb_positional_insert_remove_list: self-checking bench for the positional insert/remove list
// drives insert, remove and read requests, tracks the list and compares every response
// depends on pirl_pkg and positional_insert_remove_list
module tb_positional_insert_remove_list;

   localparam int LIST_CAP    = pirl_pkg::DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic signed [pirl_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [pirl_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

   typedef struct {
      pirl_pkg::status_type               status;
      logic signed [pirl_pkg::DATA_W-1:0] data;
      logic [pirl_pkg::COUNT_W-1:0]       count;
   } list_response_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic [1:0]                          req_op;
   logic signed [pirl_pkg::DATA_W-1:0]  req_value;
   logic [pirl_pkg::POS_W-1:0]          req_position;
   logic                                rsp_valid;
   logic [1:0]                          rsp_status;
   logic signed [pirl_pkg::DATA_W-1:0]  rsp_data_out;
   logic [pirl_pkg::COUNT_W-1:0]        rsp_entry_count;

   // shadow copy of the list and the responses still owed
   logic signed [pirl_pkg::DATA_W-1:0]  list_mem [LIST_CAP];
   int                                  list_len = 0;
   list_response_type                   due_responses[$];
   int                                  fail_count = 0;
   int                                  cycle_count = 0;
   bit                                  no_idle = 1'b0;

   positional_insert_remove_list #(.CAPACITY(LIST_CAP)) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_entry_count (rsp_entry_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // apply one accepted request to the shadow list and queue its response
   function automatic void apply_list_op(input logic [1:0] op,
                                         input logic signed [pirl_pkg::DATA_W-1:0] value,
                                         input logic [pirl_pkg::POS_W-1:0] pos);
      list_response_type rsp;
      int i;
      rsp.status = pirl_pkg::ST_OK;
      rsp.data   = '0;
      case (op)
         pirl_pkg::OP_INSERT: begin
            if (list_len >= LIST_CAP) begin
               rsp.status = pirl_pkg::ST_FULL;
            end else if (int'(pos) > list_len) begin
               rsp.status = pirl_pkg::ST_POS;
            end else begin
               for (i = list_len; i > int'(pos); i--) list_mem[i] = list_mem[i-1];
               list_mem[pos] = value;
               list_len++;
            end
         end
         pirl_pkg::OP_REMOVE, pirl_pkg::OP_READ: begin
            if (list_len == 0) begin
               rsp.status = pirl_pkg::ST_EMPTY;
            end else if (int'(pos) >= list_len) begin
               rsp.status = pirl_pkg::ST_POS;
            end else begin
               rsp.data = list_mem[pos];
               if (op == pirl_pkg::OP_REMOVE) begin
                  for (i = int'(pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                  list_len--;
               end
            end
         end
         default: ;
      endcase
      rsp.count = list_len[pirl_pkg::COUNT_W-1:0];
      due_responses.push_back(rsp);
   endfunction

   // idle length between requests: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // random value with the extremes showing up often
   function automatic logic signed [pirl_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return -1;
         3: return 0;
         default: return $urandom;
      endcase
   endfunction

   // issue one request and hold it until accepted
   task automatic send_list_request(input logic [1:0] op,
                                    input logic signed [pirl_pkg::DATA_W-1:0] value,
                                    input logic [pirl_pkg::POS_W-1:0] pos);
      int gap;
      req_op       <= op;
      req_value    <= value;
      req_position <= pos;
      start        <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      apply_list_op(op, value, pos);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // compare each response against the oldest one owed
   always @(posedge clock) begin
      list_response_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (due_responses.size() == 0) begin
            $error("unexpected response: status %0d data %0d count %0d",
                   rsp_status, rsp_data_out, rsp_entry_count);
            fail_count++;
         end else begin
            want = due_responses.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_data_out !== want.data) begin
               $error("data_out: expected %0d, got %0d", want.data, rsp_data_out);
               fail_count++;
            end
            if (rsp_entry_count !== want.count) begin
               $error("entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
               fail_count++;
            end
         end
      end
   end

   // empty list, position edges, extremes of value, unused op
   task automatic test_edges();
      send_list_request(pirl_pkg::OP_READ, 32'sd5, 8'd0);
      send_list_request(pirl_pkg::OP_REMOVE, 32'sd0, 8'd128);
      send_list_request(pirl_pkg::OP_INSERT, 32'sd7, 8'd1);
      send_list_request(pirl_pkg::OP_INSERT, VAL_MAX, 8'd0);
      send_list_request(pirl_pkg::OP_INSERT, VAL_MIN, 8'd1);
      send_list_request(pirl_pkg::OP_INSERT, 32'sd0, 8'd1);
      send_list_request(pirl_pkg::OP_INSERT, -1, 8'd0);
      send_list_request(pirl_pkg::OP_INSERT, 32'sd9, 8'd5);
      send_list_request(pirl_pkg::OP_INSERT, 32'sd9, 8'd128);
      send_list_request(pirl_pkg::OP_READ, 32'sd0, 8'd3);
      send_list_request(pirl_pkg::OP_READ, 32'sd0, 8'd4);
      send_list_request(pirl_pkg::OP_READ, 32'sd0, 8'd128);
      send_list_request(pirl_pkg::OP_READ, 32'sd0, 8'd0);
      send_list_request(OP_UNUSED, VAL_MIN, 8'd0);
      send_list_request(pirl_pkg::OP_REMOVE, 32'sd0, 8'd1);
      send_list_request(pirl_pkg::OP_REMOVE, 32'sd0, 8'd2);
      send_list_request(pirl_pkg::OP_REMOVE, 32'sd0, 8'd2);
      send_list_request(pirl_pkg::OP_READ, 32'sd0, 8'd1);
      send_list_request(pirl_pkg::OP_REMOVE, 32'sd0, 8'd0);
      send_list_request(pirl_pkg::OP_REMOVE, 32'sd0, 8'd0);
      send_list_request(pirl_pkg::OP_REMOVE, 32'sd0, 8'd0);
      send_list_request(pirl_pkg::OP_READ, 32'sd0, 8'd127);
   endtask

   // fill to capacity, check full handling, then drain to empty
   task automatic test_full_list();
      no_idle = 1'b1;
      while (list_len < LIST_CAP)
         send_list_request(pirl_pkg::OP_INSERT, pick_value(),
                           pirl_pkg::POS_W'($urandom_range(0, list_len)));
      no_idle = 1'b0;
      send_list_request(pirl_pkg::OP_INSERT, 32'sd1, 8'd0);
      send_list_request(pirl_pkg::OP_INSERT, 32'sd1, 8'd128);
      send_list_request(pirl_pkg::OP_READ, 32'sd0, 8'd127);
      send_list_request(pirl_pkg::OP_READ, 32'sd0, 8'd128);
      send_list_request(pirl_pkg::OP_REMOVE, 32'sd0, 8'd127);
      send_list_request(pirl_pkg::OP_INSERT, VAL_MAX, 8'd127);
      send_list_request(pirl_pkg::OP_READ, 32'sd0, 8'd127);
      while (list_len > 0) begin
         if ($urandom_range(0, 3) == 0)
            send_list_request(pirl_pkg::OP_READ, 32'sd0,
                              pirl_pkg::POS_W'($urandom_range(0, list_len - 1)));
         send_list_request(pirl_pkg::OP_REMOVE, 32'sd0,
                           pirl_pkg::POS_W'($urandom_range(0, list_len - 1)));
      end
      send_list_request(pirl_pkg::OP_REMOVE, 32'sd0, 8'd0);
   endtask

   // random mix in phases that grow, shrink or hold the list
   task automatic test_random_mix(input int n_items);
      int  grow_pct;
      int  roll;
      logic [1:0] op;
      logic [pirl_pkg::POS_W-1:0] pos;
      for (int k = 0; k < n_items; k++) begin
         if (k % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: grow_pct = 80;
               1: grow_pct = 20;
               default: grow_pct = 45;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         if (roll < grow_pct) op = pirl_pkg::OP_INSERT;
         else if (roll % 2 == 0) op = pirl_pkg::OP_REMOVE;
         else op = pirl_pkg::OP_READ;
         if ($urandom_range(0, 99) < 15) begin
            pos = pirl_pkg::POS_W'($urandom_range(0, LIST_CAP));
         end else if (op == pirl_pkg::OP_INSERT) begin
            pos = pirl_pkg::POS_W'($urandom_range(0, list_len));
         end else if (list_len > 0) begin
            pos = pirl_pkg::POS_W'($urandom_range(0, list_len - 1));
         end else begin
            pos = pirl_pkg::POS_W'($urandom_range(0, LIST_CAP));
         end
         send_list_request(op, pick_value(), pos);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_op       = pirl_pkg::OP_INSERT;
      req_value    = '0;
      req_position = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_edges();
      test_full_list();
      test_random_mix(100);

      // drain outstanding responses, then let the pipeline settle
      start <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
